// ===== design/esip_pkg.sv =====
// types, register map and constants shared by the speed controller modules
package esip_pkg;

   // register indexes on the csr port (byte address / 4)
   localparam logic [2:0] REG_COUNTER_MODULUS = 3'd0;
   localparam logic [2:0] REG_SPEED_SETPOINT  = 3'd1;
   localparam logic [2:0] REG_GAIN_P          = 3'd2;
   localparam logic [2:0] REG_GAIN_I          = 3'd3;
   localparam logic [2:0] REG_GAIN_D          = 3'd4;
   localparam logic [2:0] REG_DRIVE_MAX       = 3'd5;
   localparam logic [2:0] REG_DRIVE_MIN       = 3'd6;

   localparam int unsigned CSR_ADDR_W = 5;

   // x/5 as (x * 52429) >> 18, exact for x below 2**18
   localparam logic [15:0] FILT_RECIP = 16'd52429;
   localparam logic [14:0] SPEED_MAX  = 15'd32767;

   // x/100 split as 1310*hi + (72*hi + lo)/100, with hi = x >> 17
   localparam logic [10:0] DIV_HI_MULT = 11'd1310;
   // (y * 42949673) >> 32 equals y/100 for y below 2**30
   localparam logic [25:0] DIV_RECIP   = 26'd42949673;

   typedef struct packed {
      logic [15:0] encoder_count;
      logic        stop_request;
   } req_type;

   typedef struct packed {
      logic signed [15:0] drive_value;
      logic               reverse_dir;
      logic signed [15:0] speed_filtered;
   } rsp_type;

   typedef struct packed {
      logic [15:0]        counter_modulus;
      logic [14:0]        speed_setpoint;
      logic [15:0]        gain_p;
      logic [15:0]        gain_i;
      logic [15:0]        gain_d;
      logic signed [15:0] drive_max;
      logic signed [15:0] drive_min;
   } cfg_type;

   // fields that ride along the pipeline untouched
   typedef struct packed {
      logic               reverse_dir;
      logic signed [15:0] speed_filtered;
   } side_type;

   localparam cfg_type CFG_RESET = '{
      counter_modulus: 16'd65535,
      speed_setpoint:  15'd300,
      gain_p:          16'd0,
      gain_i:          16'd0,
      gain_d:          16'd0,
      drive_max:       16'sd0,
      drive_min:       16'sd0
   };

endpackage

// ===== design/esip_filter.sv =====
// count folding, speed filter, error history and pid difference terms
module esip_filter (
   input  logic                 clock,
   input  logic                 reset,
   input  esip_pkg::cfg_type    cfg,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  esip_pkg::req_type    in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output esip_pkg::side_type   out_side,
   output logic signed [17:0]   out_err_p,
   output logic signed [16:0]   out_err_i,
   output logic signed [18:0]   out_err_d
);

   logic               valid_ff;
   logic               backward_ff;
   logic signed [15:0] filt_ff;
   logic signed [16:0] e1_ff;
   logic signed [16:0] e2_ff;
   logic signed [17:0] err_p_ff;
   logic signed [18:0] err_d_ff;

   logic               load;
   logic               backward;
   logic signed [17:0] mag;
   logic signed [19:0] f4;
   logic signed [19:0] num;
   logic               num_neg;
   logic [19:0]        num_abs;
   logic [33:0]        quo_full;
   logic [15:0]        quo;
   logic [14:0]        quo_sat;
   logic signed [15:0] filt_in;
   logic signed [16:0] setp;
   logic signed [16:0] err_in;
   logic signed [17:0] err_p_in;
   logic signed [18:0] err_d_in;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_ready && in_valid;

   // count above half the modulus is reverse travel
   assign backward = in_data.encoder_count > {1'b0, cfg.counter_modulus[15:1]};
   assign mag = backward ? ($signed({2'b00, cfg.counter_modulus})
                            - $signed({2'b00, in_data.encoder_count}))
                         : $signed({2'b00, in_data.encoder_count});

   assign f4  = {{2{filt_ff[15]}}, filt_ff, 2'b00};
   assign num = backward ? (f4 - {{2{mag[17]}}, mag}) : (f4 + {{2{mag[17]}}, mag});

   // truncate toward zero: divide the magnitude, then restore the sign
   assign num_neg  = num[19];
   assign num_abs  = num_neg ? 20'(-num) : 20'(num);
   assign quo_full = num_abs[17:0] * esip_pkg::FILT_RECIP;
   assign quo      = quo_full[33:18];
   assign quo_sat  = (quo > {1'b0, esip_pkg::SPEED_MAX}) ? esip_pkg::SPEED_MAX : quo[14:0];
   assign filt_in  = num_neg ? -$signed({1'b0, quo_sat}) : $signed({1'b0, quo_sat});

   assign setp     = in_data.stop_request ? 17'sd0 : $signed({2'b00, cfg.speed_setpoint});
   assign err_in   = setp - {filt_in[15], filt_in};
   assign err_p_in = {err_in[16], err_in} - {e1_ff[16], e1_ff};
   assign err_d_in = {{2{err_in[16]}}, err_in} - {e1_ff[16], e1_ff, 1'b0}
                     + {{2{e2_ff[16]}}, e2_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         filt_ff  <= '0;
         e1_ff    <= '0;
         e2_ff    <= '0;
      end else begin
         if (in_ready) valid_ff <= in_valid;
         if (load) begin
            filt_ff <= filt_in;
            e1_ff   <= err_in;
            e2_ff   <= e1_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         backward_ff <= backward;
         err_p_ff    <= err_p_in;
         err_d_ff    <= err_d_in;
      end
   end

   assign out_valid               = valid_ff;
   assign out_side.reverse_dir    = backward_ff;
   assign out_side.speed_filtered = filt_ff;
   assign out_err_p               = err_p_ff;
   assign out_err_i               = e1_ff;
   assign out_err_d               = err_d_ff;

   a_history_shift: assert property (@(posedge clock) disable iff (reset)
      (!reset && load) |=> (e2_ff == $past(e1_ff)))
      else $error("error history did not shift on a beat");

   a_filt_range: assert property (@(posedge clock) disable iff (reset)
      filt_ff[15:0] != 16'h8000)
      else $error("filtered speed left its saturation range");

endmodule

// ===== design/esip_gain.sv =====
// registered gain products of the three pid terms
module esip_gain (
   input  logic                 clock,
   input  logic                 reset,
   input  esip_pkg::cfg_type    cfg,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  esip_pkg::side_type   in_side,
   input  logic signed [17:0]   in_err_p,
   input  logic signed [16:0]   in_err_i,
   input  logic signed [18:0]   in_err_d,
   output logic                 out_valid,
   input  logic                 out_ready,
   output esip_pkg::side_type   out_side,
   output logic signed [35:0]   out_prod_p,
   output logic signed [35:0]   out_prod_i,
   output logic signed [35:0]   out_prod_d
);

   logic                 valid_ff;
   esip_pkg::side_type   side_ff;
   logic signed [35:0]   prod_p_ff;
   logic signed [35:0]   prod_i_ff;
   logic signed [35:0]   prod_d_ff;

   logic                 load;
   logic signed [35:0]   prod_p_in;
   logic signed [35:0]   prod_i_in;
   logic signed [35:0]   prod_d_in;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_ready && in_valid;

   assign prod_p_in = $signed({1'b0, cfg.gain_p}) * in_err_p;
   assign prod_i_in = $signed({1'b0, cfg.gain_i}) * in_err_i;
   assign prod_d_in = $signed({1'b0, cfg.gain_d}) * in_err_d;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         side_ff   <= in_side;
         prod_p_ff <= prod_p_in;
         prod_i_ff <= prod_i_in;
         prod_d_ff <= prod_d_in;
      end
   end

   assign out_valid  = valid_ff;
   assign out_side   = side_ff;
   assign out_prod_p = prod_p_ff;
   assign out_prod_i = prod_i_ff;
   assign out_prod_d = prod_d_ff;

endmodule

// ===== design/esip_div100.sv =====
// sum of pid products divided by 100, truncating toward zero, over two stages
module esip_div100 (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  esip_pkg::side_type   in_side,
   input  logic signed [35:0]   in_prod_p,
   input  logic signed [35:0]   in_prod_i,
   input  logic signed [35:0]   in_prod_d,
   output logic                 out_valid,
   input  logic                 out_ready,
   output esip_pkg::side_type   out_side,
   output logic signed [29:0]   out_inc
);

   logic                 split_valid_ff;
   esip_pkg::side_type   split_side_ff;
   logic                 neg_ff;
   logic [28:0]          hi_ff;
   logic [24:0]          x_ff;

   logic                 quo_valid_ff;
   esip_pkg::side_type   quo_side_ff;
   logic signed [29:0]   inc_ff;

   logic                 split_ready;
   logic                 split_load;
   logic                 quo_ready;
   logic                 quo_load;
   logic signed [36:0]   sum;
   logic                 neg_in;
   logic [36:0]          sum_abs;
   logic [17:0]          hi_part;
   logic [16:0]          lo_part;
   logic [28:0]          hi_in;
   logic [24:0]          x_in;
   logic [50:0]          x_prod;
   logic [28:0]          quo;
   logic signed [29:0]   inc_in;

   assign quo_ready   = !quo_valid_ff || out_ready;
   assign quo_load    = quo_ready && split_valid_ff;
   assign split_ready = !split_valid_ff || quo_ready;
   assign split_load  = split_ready && in_valid;
   assign in_ready    = split_ready;

   // magnitude stays below 2**35
   assign sum     = {in_prod_p[35], in_prod_p} + {in_prod_i[35], in_prod_i}
                    + {in_prod_d[35], in_prod_d};
   assign neg_in  = sum[36];
   assign sum_abs = neg_in ? 37'(-sum) : 37'(sum);
   assign hi_part = sum_abs[34:17];
   assign lo_part = sum_abs[16:0];

   // 2**17 = 1310*100 + 72
   assign hi_in = hi_part * esip_pkg::DIV_HI_MULT;
   assign x_in  = {1'b0, hi_part, 6'b000000} + {4'b0000, hi_part, 3'b000}
                  + {8'b00000000, lo_part};

   assign x_prod = x_ff * esip_pkg::DIV_RECIP;
   assign quo    = hi_ff + {10'b0000000000, x_prod[50:32]};
   assign inc_in = neg_ff ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

   always_ff @(posedge clock) begin
      if (reset) begin
         split_valid_ff <= 1'b0;
         quo_valid_ff   <= 1'b0;
      end else begin
         if (split_ready) split_valid_ff <= in_valid;
         if (quo_ready) quo_valid_ff <= split_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (split_load) begin
         split_side_ff <= in_side;
         neg_ff        <= neg_in;
         hi_ff         <= hi_in;
         x_ff          <= x_in;
      end
      if (quo_load) begin
         quo_side_ff <= split_side_ff;
         inc_ff      <= inc_in;
      end
   end

   assign out_valid = quo_valid_ff;
   assign out_side  = quo_side_ff;
   assign out_inc   = inc_ff;

endmodule

// ===== design/esip_drive.sv =====
// drive accumulator with upper then lower clamp, feeding the result register
module esip_drive (
   input  logic                 clock,
   input  logic                 reset,
   input  esip_pkg::cfg_type    cfg,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  esip_pkg::side_type   in_side,
   input  logic signed [29:0]   in_inc,
   output logic                 out_valid,
   input  logic                 out_ready,
   output esip_pkg::rsp_type    out_data
);

   logic                 valid_ff;
   logic signed [15:0]   accum_ff;
   esip_pkg::rsp_type    rsp_ff;

   logic                 load;
   logic signed [30:0]   sum;
   logic signed [30:0]   max_ext;
   logic signed [30:0]   min_ext;
   logic signed [30:0]   upper;
   logic signed [15:0]   accum_in;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_ready && in_valid;

   assign sum     = {{15{accum_ff[15]}}, accum_ff} + {in_inc[29], in_inc};
   assign max_ext = {{15{cfg.drive_max[15]}}, cfg.drive_max};
   assign min_ext = {{15{cfg.drive_min[15]}}, cfg.drive_min};

   // lower clamp wins when the bounds cross
   assign upper    = (sum > max_ext) ? max_ext : sum;
   assign accum_in = (upper < min_ext) ? cfg.drive_min : upper[15:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         accum_ff <= '0;
      end else begin
         if (in_ready) valid_ff <= in_valid;
         if (load) accum_ff <= accum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff.drive_value    <= accum_in;
         rsp_ff.reverse_dir    <= in_side.reverse_dir;
         rsp_ff.speed_filtered <= in_side.speed_filtered;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = rsp_ff;

   a_drive_matches_accum: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (rsp_ff.drive_value == accum_ff))
      else $error("result drive differs from the accumulator");

endmodule

// ===== design/encoder_speed_incremental_pid.sv =====
// incremental pid speed controller: csr block, input register and pipeline
// a result passes the input, filter, gain, /100 split, /100 quotient and drive registers in turn
// throughput: one beat per cycle while rsp_stall is low; filter and error history close in one stage,
// the drive accumulator in the last, the /100 split over two stages in between
// reset (synchronous): pipeline emptied, state zeroed, registers to defaults
module encoder_speed_incremental_pid (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  esip_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output esip_pkg::rsp_type                   rsp_data,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [esip_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [31:0]                         csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready
);

   esip_pkg::cfg_type    cfg_ff;
   logic                 s0_valid_ff;
   esip_pkg::req_type    s0_data_ff;

   logic                 s0_ready;
   logic                 csr_write;
   logic [2:0]           csr_index;

   logic                 filt_ready;
   logic                 filt_valid;
   esip_pkg::side_type   filt_side;
   logic signed [17:0]   filt_err_p;
   logic signed [16:0]   filt_err_i;
   logic signed [18:0]   filt_err_d;

   logic                 gain_ready;
   logic                 gain_valid;
   esip_pkg::side_type   gain_side;
   logic signed [35:0]   gain_prod_p;
   logic signed [35:0]   gain_prod_i;
   logic signed [35:0]   gain_prod_d;

   logic                 div_ready;
   logic                 div_valid;
   esip_pkg::side_type   div_side;
   logic signed [29:0]   div_inc;

   logic                 drv_ready;

   // csr port
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[4:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= esip_pkg::CFG_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            esip_pkg::REG_COUNTER_MODULUS: cfg_ff.counter_modulus <= csr_pwdata[15:0];
            esip_pkg::REG_SPEED_SETPOINT:  cfg_ff.speed_setpoint  <= csr_pwdata[14:0];
            esip_pkg::REG_GAIN_P:          cfg_ff.gain_p          <= csr_pwdata[15:0];
            esip_pkg::REG_GAIN_I:          cfg_ff.gain_i          <= csr_pwdata[15:0];
            esip_pkg::REG_GAIN_D:          cfg_ff.gain_d          <= csr_pwdata[15:0];
            esip_pkg::REG_DRIVE_MAX:       cfg_ff.drive_max       <= csr_pwdata[15:0];
            esip_pkg::REG_DRIVE_MIN:       cfg_ff.drive_min       <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         esip_pkg::REG_COUNTER_MODULUS: csr_prdata = {16'h0000, cfg_ff.counter_modulus};
         esip_pkg::REG_SPEED_SETPOINT:  csr_prdata = {17'h00000, cfg_ff.speed_setpoint};
         esip_pkg::REG_GAIN_P:          csr_prdata = {16'h0000, cfg_ff.gain_p};
         esip_pkg::REG_GAIN_I:          csr_prdata = {16'h0000, cfg_ff.gain_i};
         esip_pkg::REG_GAIN_D:          csr_prdata = {16'h0000, cfg_ff.gain_d};
         esip_pkg::REG_DRIVE_MAX:       csr_prdata = {{16{cfg_ff.drive_max[15]}},
                                                      cfg_ff.drive_max};
         esip_pkg::REG_DRIVE_MIN:       csr_prdata = {{16{cfg_ff.drive_min[15]}},
                                                      cfg_ff.drive_min};
         default:                       csr_prdata = 32'h0000_0000;
      endcase
   end

   // input register
   assign s0_ready  = !s0_valid_ff || filt_ready;
   assign req_stall = !s0_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (s0_ready) begin
         s0_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s0_ready && req_valid) s0_data_ff <= req_data;
   end

   esip_filter u_filter (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (s0_valid_ff),
      .in_ready  (filt_ready),
      .in_data   (s0_data_ff),
      .out_valid (filt_valid),
      .out_ready (gain_ready),
      .out_side  (filt_side),
      .out_err_p (filt_err_p),
      .out_err_i (filt_err_i),
      .out_err_d (filt_err_d)
   );

   esip_gain u_gain (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .in_valid   (filt_valid),
      .in_ready   (gain_ready),
      .in_side    (filt_side),
      .in_err_p   (filt_err_p),
      .in_err_i   (filt_err_i),
      .in_err_d   (filt_err_d),
      .out_valid  (gain_valid),
      .out_ready  (div_ready),
      .out_side   (gain_side),
      .out_prod_p (gain_prod_p),
      .out_prod_i (gain_prod_i),
      .out_prod_d (gain_prod_d)
   );

   esip_div100 u_div100 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (gain_valid),
      .in_ready  (div_ready),
      .in_side   (gain_side),
      .in_prod_p (gain_prod_p),
      .in_prod_i (gain_prod_i),
      .in_prod_d (gain_prod_d),
      .out_valid (div_valid),
      .out_ready (drv_ready),
      .out_side  (div_side),
      .out_inc   (div_inc)
   );

   esip_drive u_drive (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (div_valid),
      .in_ready  (drv_ready),
      .in_side   (div_side),
      .in_inc    (div_inc),
      .out_valid (rsp_valid),
      .out_ready (!rsp_stall),
      .out_data  (rsp_data)
   );

   a_empty_input_takes_beat: assert property (@(posedge clock) disable iff (reset)
      !s0_valid_ff |-> !req_stall)
      else $error("input stalled while its register is empty");

endmodule

// ===== dv/tb_encoder_speed_incremental_pid.sv =====
// self-checking testbench for the encoder speed incremental pid controller
module tb_encoder_speed_incremental_pid;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned QUIET_LIMIT  = 2000;
   localparam int unsigned DRAIN_CYCLES = 12;
   localparam int unsigned PHASES       = 10;
   localparam int unsigned PHASE_TICKS  = 110;
   localparam logic [2:0]  REG_UNMAPPED = 3'd7;

   logic                            clock;
   logic                            reset;
   logic                            req_valid;
   logic                            req_stall;
   esip_pkg::req_type               req_data;
   logic                            rsp_valid;
   logic                            rsp_stall;
   esip_pkg::rsp_type               rsp_data;
   logic                            csr_psel;
   logic                            csr_penable;
   logic                            csr_pwrite;
   logic [esip_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0]                     csr_pwdata;
   logic [31:0]                     csr_prdata;
   logic                            csr_pready;

   encoder_speed_incremental_pid dut (.*);

   // controller copy: register file and loop state
   esip_pkg::cfg_type ctl;
   longint  filt_speed;
   longint  err_last;
   longint  err_prev;
   longint  drive_acc;

   esip_pkg::rsp_type tick_expected_q[$];
   bit          idle_on;
   int unsigned failures;
   int unsigned ticks_sent;
   int unsigned ticks_checked;
   int unsigned settings_done;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // one control tick of the speed loop
   function automatic esip_pkg::rsp_type control_tick(esip_pkg::req_type beat);
      longint  count;
      longint  mag;
      longint  filt;
      longint  setp;
      longint  err;
      longint  inc;
      longint  drive;
      logic    backward;
      esip_pkg::rsp_type res;
      count    = longint'(beat.encoder_count);
      backward = count > longint'(ctl.counter_modulus >> 1);
      mag      = backward ? longint'(ctl.counter_modulus) - count : count;
      filt     = backward ? (4 * filt_speed - mag) / 5 : (4 * filt_speed + mag) / 5;
      if (filt > 32767) filt = 32767;
      if (filt < -32767) filt = -32767;
      setp = beat.stop_request ? 0 : longint'(ctl.speed_setpoint);
      err  = setp - filt;
      inc  = (longint'(ctl.gain_p) * (err - err_last)
            + longint'(ctl.gain_i) * err
            + longint'(ctl.gain_d) * (err - 2 * err_last + err_prev)) / 100;
      drive = drive_acc + inc;
      if (drive > longint'(ctl.drive_max)) drive = longint'(ctl.drive_max);
      if (drive < longint'(ctl.drive_min)) drive = longint'(ctl.drive_min);
      filt_speed = filt;
      err_prev   = err_last;
      err_last   = err;
      drive_acc  = drive;
      res.drive_value    = drive[15:0];
      res.reverse_dir    = backward;
      res.speed_filtered = filt[15:0];
      return res;
   endfunction

   task automatic send_tick(logic [15:0] count, logic stop);
      esip_pkg::req_type beat;
      int unsigned gap;
      beat.encoder_count = count;
      beat.stop_request  = stop;
      if (idle_on && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 19);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tick_expected_q.push_back(control_tick(beat));
      ticks_sent++;
   endtask

   // sender holds off until every pending result beat is back
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tick_expected_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         esip_pkg::REG_COUNTER_MODULUS: ctl.counter_modulus = value[15:0];
         esip_pkg::REG_SPEED_SETPOINT:  ctl.speed_setpoint  = value[14:0];
         esip_pkg::REG_GAIN_P:          ctl.gain_p          = value[15:0];
         esip_pkg::REG_GAIN_I:          ctl.gain_i          = value[15:0];
         esip_pkg::REG_GAIN_D:          ctl.gain_d          = value[15:0];
         esip_pkg::REG_DRIVE_MAX:       ctl.drive_max       = value[15:0];
         esip_pkg::REG_DRIVE_MIN:       ctl.drive_min       = value[15:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic program_controller(logic [15:0] modulus, logic [14:0] setpoint,
                                     logic [15:0] kp, logic [15:0] ki, logic [15:0] kd,
                                     logic signed [15:0] dmax, logic signed [15:0] dmin,
                                     bit junk_on);
      logic [31:0] junk;
      drain_results();
      junk = junk_on ? $urandom : 32'h0;
      write_reg(esip_pkg::REG_COUNTER_MODULUS, {junk[31:16], modulus});
      write_reg(esip_pkg::REG_SPEED_SETPOINT,  {junk[31:15], setpoint});
      write_reg(esip_pkg::REG_GAIN_P,          {junk[31:16], kp});
      write_reg(esip_pkg::REG_GAIN_I,          {junk[31:16], ki});
      write_reg(esip_pkg::REG_GAIN_D,          {junk[31:16], kd});
      write_reg(esip_pkg::REG_DRIVE_MAX,       {junk[31:16], dmax});
      write_reg(esip_pkg::REG_DRIVE_MIN,       {junk[31:16], dmin});
      settings_done++;
   endtask

   task automatic test_reset_defaults();
      send_tick(16'h0000, 1'b0);
      send_tick(16'h7fff, 1'b0);
      send_tick(16'h8000, 1'b0);
      send_tick(16'hffff, 1'b1);
      send_tick(16'h0001, 1'b1);
   endtask

   task automatic test_count_folding();
      program_controller(16'd100, 15'd300, 16'd10, 16'd5, 16'd2, 16'sd1000, -16'sd1000, 0);
      // write to an unmapped register must leave the map alone
      write_reg(REG_UNMAPPED, $urandom);
      send_tick(16'd50, 1'b0);
      send_tick(16'd51, 1'b0);
      send_tick(16'd100, 1'b0);
      // count beyond the modulus gives a negative backward magnitude
      send_tick(16'hffff, 1'b0);
      program_controller(16'd0, 15'd300, 16'd10, 16'd5, 16'd2, 16'sd1000, -16'sd1000, 0);
      send_tick(16'd0, 1'b0);
      send_tick(16'd1, 1'b0);
      program_controller(16'd1, 15'd300, 16'd10, 16'd5, 16'd2, 16'sd1000, -16'sd1000, 0);
      send_tick(16'd1, 1'b0);
   endtask

   task automatic test_filter_saturation();
      program_controller(16'd1, 15'd32767, 16'd0, 16'd0, 16'd0, 16'sd0, 16'sd0, 0);
      repeat (5) send_tick(16'hffff, 1'b0);
   endtask

   task automatic test_pid_response();
      program_controller(16'hffff, 15'h7fff, 16'hffff, 16'hffff, 16'hffff,
                         16'sh7fff, 16'sh8000, 0);
      send_tick(16'd0, 1'b0);
      send_tick(16'd0, 1'b0);
      send_tick(16'd0, 1'b1);
      send_tick(16'd100, 1'b1);
      send_tick(16'h7fff, 1'b0);
      // crossed bounds: the lower clamp wins
      program_controller(16'hffff, 15'd0, 16'd50, 16'd20, 16'd10, -16'sd100, 16'sd100, 0);
      send_tick(16'd0, 1'b0);
      send_tick(16'd200, 1'b1);
   endtask

   task automatic test_random_phases();
      logic [15:0]        modulus;
      logic [14:0]        setpoint;
      logic [15:0]        kp;
      logic [15:0]        ki;
      logic [15:0]        kd;
      logic signed [15:0] dmax;
      logic signed [15:0] dmin;
      int                 lim;
      int                 travel;
      int                 cnt;
      logic [15:0]        count;
      for (int p = 0; p < PHASES; p++) begin
         idle_on = (p < PHASES - 1);
         case ($urandom_range(0, 3))
            0:       modulus = 16'hffff;
            1:       modulus = 16'($urandom_range(1, 300));
            default: modulus = 16'($urandom);
         endcase
         setpoint = ($urandom_range(0, 5) == 0) ? 15'($urandom) : 15'($urandom_range(0, 2000));
         if ($urandom_range(0, 4) == 0) begin
            kp = 16'($urandom);
            ki = 16'($urandom);
            kd = 16'($urandom);
         end else begin
            kp = 16'($urandom_range(0, 400));
            ki = 16'($urandom_range(0, 400));
            kd = 16'($urandom_range(0, 400));
         end
         if ($urandom_range(0, 5) == 0) begin
            dmax = 16'($urandom);
            dmin = 16'($urandom);
         end else begin
            dmax = 16'($urandom_range(0, 32767));
            dmin = 16'(-int'($urandom_range(0, 32768)));
         end
         program_controller(modulus, setpoint, kp, ki, kd, dmax, dmin, 1);
         lim    = int'(ctl.counter_modulus >> 1);
         travel = 0;
         for (int i = 0; i < PHASE_TICKS; i++) begin
            if ($urandom_range(0, 9) < 7) begin
               // steady motion: slowly drifting travel per tick
               travel = travel + int'($urandom_range(0, 40)) - 20;
               if (travel > lim || -travel > lim) travel = 0;
               cnt   = (travel >= 0) ? travel : int'(ctl.counter_modulus) + travel;
               count = cnt[15:0];
            end else begin
               count = 16'($urandom);
            end
            send_tick(count, $urandom_range(0, 7) == 0);
            if (i == PHASE_TICKS / 2 || $urandom_range(0, 63) == 0) drain_results();
         end
      end
   endtask

   // result side: checks each beat and stalls in random bursts
   initial begin : rsp_monitor
      int unsigned       hold;
      esip_pkg::rsp_type want;
      hold = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (tick_expected_q.size() == 0) begin
               $error("unexpected result beat: drive_value %0d reverse_dir %0d %s %0d",
                      rsp_data.drive_value, rsp_data.reverse_dir, "speed_filtered",
                      rsp_data.speed_filtered);
               failures++;
            end else begin
               want = tick_expected_q.pop_front();
               ticks_checked++;
               if (rsp_data.drive_value !== want.drive_value) begin
                  $error("drive_value expected %0d actual %0d",
                         want.drive_value, rsp_data.drive_value);
                  failures++;
               end
               if (rsp_data.reverse_dir !== want.reverse_dir) begin
                  $error("reverse_dir expected %0d actual %0d",
                         want.reverse_dir, rsp_data.reverse_dir);
                  failures++;
               end
               if (rsp_data.speed_filtered !== want.speed_filtered) begin
                  $error("speed_filtered expected %0d actual %0d",
                         want.speed_filtered, rsp_data.speed_filtered);
                  failures++;
               end
            end
         end
         if (hold > 0) hold--;
         else if (idle_on && $urandom_range(0, 7) == 0) hold = $urandom_range(1, 19);
         rsp_stall <= (hold > 0);
      end
   end

   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
             || (csr_psel && csr_penable)) quiet = 0;
         else quiet++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      ctl         = esip_pkg::CFG_RESET;
      filt_speed  = 0;
      err_last    = 0;
      err_prev    = 0;
      drive_acc   = 0;
      failures      = 0;
      ticks_sent    = 0;
      ticks_checked = 0;
      settings_done = 0;
      idle_on       = 1'b1;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_data    <= '0;
      rsp_stall   <= 1'b0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_count_folding();
      test_filter_saturation();
      test_pid_response();
      test_random_phases();
      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d ticks under %0d register settings, %0d result beats checked",
               ticks_sent, settings_done, ticks_checked);
      $display("folding, filter saturation, clamps and stop requests exercised");
      if (failures == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule
